// ===== design/lcd_line_timing_stat_dma_macros.svh =====
// Assertion macros for the LCD timing block.
// Included by RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef LCD_LINE_TIMING_STAT_DMA_MACROS_SVH
`define LCD_LINE_TIMING_STAT_DMA_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LCDSTAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LCDSTAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcdstat_pkg.sv =====
// Shared types and constants for the LCD line timing / STAT / OAM DMA block.
// No dependencies.
`default_nettype none

package lcdstat_pkg;

  localparam logic [9:0] DOTS_PER_LINE   = 10'd456;
  localparam logic [8:0] LINES_PER_FRAME = 9'd154;
  localparam logic [7:0] LAST_VISIBLE    = 8'd143;
  localparam logic [8:0] FIRST_VBLANK    = 9'd144;
  localparam logic [7:0] LAST_LINE       = 8'd153;
  localparam logic [8:0] OAM_DOTS        = 9'd92;
  localparam logic [8:0] HBLANK_START    = 9'd252;
  localparam logic [8:0] DMA_END_SLOT    = 9'd161;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DISPLAY_ENABLE = 3'd0,
    CFG_HBLANK_IRQ_EN  = 3'd1,
    CFG_VBLANK_IRQ_EN  = 3'd2,
    CFG_OAM_IRQ_EN     = 3'd3,
    CFG_COMPARE_IRQ_EN = 3'd4,
    CFG_COMPARE_LINE   = 3'd5,
    CFG_DOUBLE_SPEED   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  // DMA sequencer result for one item
  typedef struct packed {
    logic        read_valid;
    logic [15:0] read_address;
    logic [7:0]  byte_index;
    logic        busy;
  } dma_result_t;

endpackage

`default_nettype wire

// ===== design/lcdstat_dma.sv =====
// OAM DMA sequencer: one step per dot tick, one byte request every 2 or 4 ticks.
// Depends on lcdstat_pkg.
`default_nettype none

module lcdstat_dma import lcdstat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        step,
  input  wire logic [7:0]  page,
  input  wire logic        double_speed,
  output dma_result_t      result
);

  logic       active, active_next;
  logic [9:0] tick_count, tick_count_next;
  logic [7:0] dma_page, dma_page_next;

  logic       phase_zero;
  logic [8:0] slot;
  logic       acts, ending;

  always_comb begin
    phase_zero = double_speed ? !tick_count[0] : (tick_count[1:0] == 2'd0);
    slot       = double_speed ? tick_count[9:1] : {1'b0, tick_count[9:2]};
    // slot 0 is warm-up; slots past the last byte close the sequence
    acts       = step && active && phase_zero && (slot != 9'd0);
    ending     = acts && (slot >= DMA_END_SLOT);
  end

  always_comb begin
    active_next     = active;
    tick_count_next = tick_count;
    dma_page_next   = dma_page;
    if (start) begin
      active_next     = 1'b1;
      tick_count_next = 10'd0;
      dma_page_next   = page;
    end else if (step && active) begin
      tick_count_next = tick_count + 10'd1;
      if (ending) begin
        active_next = 1'b0;
      end
    end
  end

  always_comb begin
    result.read_valid   = acts && !ending;
    result.byte_index   = result.read_valid ? (slot[7:0] - 8'd1) : 8'd0;
    result.read_address = result.read_valid ? {dma_page, result.byte_index} : 16'd0;
    result.busy         = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      tick_count <= 10'd0;
      dma_page   <= 8'd0;
    end else begin
      active     <= active_next;
      tick_count <= tick_count_next;
      dma_page   <= dma_page_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lcd_line_timing_stat_dma.sv =====
// Top level: dot/line counters, mode and STAT logic, output register; DMA in lcdstat_dma.
// Depends on lcdstat_pkg, lcdstat_dma and lcd_line_timing_stat_dma_macros.svh.
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------------
//  in      | in_valid / in_ready          | action, dma_source_page
//  out     | out_valid / out_ready        | lcd_mode .. dma_busy (12 fields)
//  cfg     | cfg_write_enable (no wait)   | cfg_index, cfg_data
//
// One item per cycle unless out_ready stalls; output register shows it the next cycle.
// in_ready is high whenever the output register is empty or being drained.
// All timing state updates in one pass at the accept edge: counters, STAT edge, DMA start or step.
// Synchronous reset clears counters, config and the output valid; no clearing pass.
`default_nettype none

module lcd_line_timing_stat_dma import lcdstat_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   action,
  input  wire logic [7:0]             dma_source_page,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  lcd_mode,
  output logic [7:0]                  line_number,
  output logic [8:0]                  dot_number,
  output logic                        compare_match,
  output logic                        stat_irq,
  output logic                        vblank_irq,
  output logic                        hblank_pulse,
  output logic                        frame_done,
  output logic                        dma_read_valid,
  output logic [15:0]                 dma_read_address,
  output logic [7:0]                  oam_byte_index,
  output logic                        dma_busy,
  input  wire logic                   cfg_write_enable,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "lcd_line_timing_stat_dma_macros.svh"

  // configuration
  logic       display_enable, hblank_irq_enable, vblank_irq_enable;
  logic       oam_irq_enable, compare_irq_enable, double_speed;
  logic [7:0] compare_line;

  // timing state
  logic [8:0] dot_counter, dot_counter_next;
  logic [7:0] line_counter, line_counter_next;
  logic       stat_line_prev, stat_line_prev_next;

  logic        accept, tick, start;
  lcd_mode_t   mode;
  logic [7:0]  ly_eff;
  logic        match, cond;
  logic [9:0]  dot_inc;
  logic [8:0]  line_inc;
  logic        line_wrap;
  logic        stat_now, hbl_now, frame_now, vbl_now;
  dma_result_t dma_res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && !action;
  assign start    = accept && action;

  always_comb begin
    if (line_counter > LAST_VISIBLE) begin
      mode = MODE_VBLANK;
    end else if (dot_counter < OAM_DOTS) begin
      mode = MODE_OAM;
    end else if (dot_counter < HBLANK_START) begin
      mode = MODE_XFER;
    end else begin
      mode = MODE_HBLANK;
    end
    // late in the last line the line register compares as zero
    ly_eff = ((line_counter == LAST_LINE) && (dot_counter >= OAM_DOTS)) ? 8'd0 : line_counter;
    match  = (ly_eff == compare_line);
    cond   = (hblank_irq_enable && (mode == MODE_HBLANK)) ||
             (vblank_irq_enable && (mode == MODE_VBLANK)) ||
             (oam_irq_enable    && (mode == MODE_OAM))    ||
             (compare_irq_enable && match);
  end

  always_comb begin
    dot_inc   = {1'b0, dot_counter} + 10'd1;
    line_inc  = {1'b0, line_counter} + 9'd1;
    line_wrap = (dot_inc >= DOTS_PER_LINE);

    stat_now  = tick && cond && !stat_line_prev;
    hbl_now   = tick && display_enable && (line_counter <= LAST_VISIBLE) &&
                (dot_counter == HBLANK_START);
    frame_now = tick && line_wrap && (line_inc == FIRST_VBLANK);
    vbl_now   = frame_now && display_enable;

    dot_counter_next    = dot_counter;
    line_counter_next   = line_counter;
    stat_line_prev_next = stat_line_prev;
    if (tick) begin
      stat_line_prev_next = cond;
      if (line_wrap) begin
        dot_counter_next  = 9'd0;
        line_counter_next = (line_inc >= LINES_PER_FRAME) ? 8'd0 : line_inc[7:0];
      end else begin
        dot_counter_next  = dot_inc[8:0];
      end
    end
  end

  lcdstat_dma u_dma (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .step         (tick),
    .page         (dma_source_page),
    .double_speed (double_speed),
    .result       (dma_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable     <= 1'b0;
      hblank_irq_enable  <= 1'b0;
      vblank_irq_enable  <= 1'b0;
      oam_irq_enable     <= 1'b0;
      compare_irq_enable <= 1'b0;
      compare_line       <= 8'd0;
      double_speed       <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DISPLAY_ENABLE: display_enable     <= cfg_data[0];
        CFG_HBLANK_IRQ_EN:  hblank_irq_enable  <= cfg_data[0];
        CFG_VBLANK_IRQ_EN:  vblank_irq_enable  <= cfg_data[0];
        CFG_OAM_IRQ_EN:     oam_irq_enable     <= cfg_data[0];
        CFG_COMPARE_IRQ_EN: compare_irq_enable <= cfg_data[0];
        CFG_COMPARE_LINE:   compare_line       <= cfg_data;
        CFG_DOUBLE_SPEED:   double_speed       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter    <= 9'd0;
      line_counter   <= 8'd0;
      stat_line_prev <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      dot_counter    <= dot_counter_next;
      line_counter   <= line_counter_next;
      stat_line_prev <= stat_line_prev_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      lcd_mode         <= mode;
      line_number      <= line_counter;
      dot_number       <= dot_counter;
      compare_match    <= match;
      stat_irq         <= stat_now;
      vblank_irq       <= vbl_now;
      hblank_pulse     <= hbl_now;
      frame_done       <= frame_now;
      dma_read_valid   <= dma_res.read_valid;
      dma_read_address <= dma_res.read_address;
      oam_byte_index   <= dma_res.byte_index;
      dma_busy         <= dma_res.busy;
    end
  end

  `LCDSTAT_ASSERT_IMPL(a_read_implies_busy, out_valid && dma_read_valid, dma_busy,
    "DMA request issued while sequence reported idle")
  `LCDSTAT_ASSERT_IMPL(a_frame_at_line_end, out_valid && frame_done,
    (line_number == LAST_VISIBLE) && (dot_number == 9'd455), "frame_done at wrong dot")
  `LCDSTAT_ASSERT_IMPL(a_hblank_in_mode0, out_valid && hblank_pulse,
    (lcd_mode == MODE_HBLANK) && (dot_number == HBLANK_START), "hblank pulse outside mode 0 start")
  `LCDSTAT_ASSERT_IMPL(a_vblank_needs_frame, out_valid && vblank_irq, frame_done,
    "vblank_irq without frame_done")
  `LCDSTAT_ASSERT_NEXT(a_start_result, start,
    out_valid && dma_busy && !stat_irq && !dma_read_valid, "DMA start result malformed")

endmodule

`default_nettype wire

// ===== bench/lcd_line_timing_stat_dma_tb.sv =====
// Testbench for lcd_line_timing_stat_dma: dot/line timing, STAT edge, vblank/hblank and OAM DMA.
// Predicts every result from its own copy of the counters and registers; needs only lcdstat_pkg
// and the block itself.
`default_nettype none

module lcd_line_timing_stat_dma_tb import lcdstat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 36;
  localparam int RUN_TICKS     = 110;
  localparam int RUN_TAIL      = 40;
  localparam int LATE_DMA_LEAD = 30;

  typedef struct packed {
    lcd_mode_t   mode;
    logic [7:0]  line;
    logic [8:0]  dot;
    logic        match;
    logic        stat;
    logic        vbl;
    logic        hbl;
    logic        frame;
    logic        rd_valid;
    logic [15:0] rd_addr;
    logic [7:0]  rd_idx;
    logic        busy;
  } lcd_status_t;

  class lcd_status_scoreboard;
    bit disp_en, hbl_irq_en, vbl_irq_en, oam_irq_en, cmp_irq_en, dbl_speed;
    bit [7:0] cmp_line;
    bit [8:0] dot_cnt;
    bit [7:0] line_cnt;
    bit stat_level, dma_on;
    bit [9:0] dma_steps;
    bit [7:0] dma_src;
    lcd_status_t expected_status[$];
    int errors, checked, items, frames, dma_reads;

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DISPLAY_ENABLE: disp_en = val[0];
        CFG_HBLANK_IRQ_EN:  hbl_irq_en = val[0];
        CFG_VBLANK_IRQ_EN:  vbl_irq_en = val[0];
        CFG_OAM_IRQ_EN:     oam_irq_en = val[0];
        CFG_COMPARE_IRQ_EN: cmp_irq_en = val[0];
        CFG_COMPARE_LINE:   cmp_line = val[7:0];
        CFG_DOUBLE_SPEED:   dbl_speed = val[0];
        default: ;
      endcase
    endfunction

    function lcd_status_t predict_status(bit act, bit [7:0] page);
      lcd_status_t r;
      bit cond;
      bit [7:0] eff_line;
      bit [9:0] slot;
      bit [1:0] phase;
      r = '0;
      if (line_cnt > LAST_VISIBLE) r.mode = MODE_VBLANK;
      else if (dot_cnt < OAM_DOTS) r.mode = MODE_OAM;
      else if (dot_cnt < HBLANK_START) r.mode = MODE_XFER;
      else r.mode = MODE_HBLANK;
      // late in the last line the comparator already sees line 0
      eff_line = (line_cnt == LAST_LINE && dot_cnt >= OAM_DOTS) ? 8'd0 : line_cnt;
      r.match = (eff_line == cmp_line);
      r.line = line_cnt;
      r.dot = dot_cnt;
      if (act) begin
        dma_on = 1'b1;
        dma_steps = '0;
        dma_src = page;
      end else begin
        cond = (hbl_irq_en && r.mode == MODE_HBLANK) || (vbl_irq_en && r.mode == MODE_VBLANK) ||
               (oam_irq_en && r.mode == MODE_OAM) || (cmp_irq_en && r.match);
        r.stat = cond && !stat_level;
        stat_level = cond;
        r.hbl = disp_en && line_cnt <= LAST_VISIBLE && dot_cnt == HBLANK_START;
        if (dma_on) begin
          phase = dbl_speed ? {1'b0, dma_steps[0]} : dma_steps[1:0];
          slot = dbl_speed ? (dma_steps >> 1) : (dma_steps >> 2);
          dma_steps = dma_steps + 10'd1;
          if (phase == 2'd0 && slot != 10'd0) begin
            if (slot >= DMA_END_SLOT) begin
              dma_on = 1'b0;
            end else begin
              r.rd_valid = 1'b1;
              r.rd_idx = slot[7:0] - 8'd1;
              r.rd_addr = {dma_src, r.rd_idx};
            end
          end
        end
        if (dot_cnt >= DOTS_PER_LINE - 1) begin
          dot_cnt = '0;
          line_cnt = line_cnt + 8'd1;
          if (line_cnt == FIRST_VBLANK) begin
            r.frame = 1'b1;
            r.vbl = disp_en;
          end
          if (line_cnt >= LINES_PER_FRAME) line_cnt = '0;
        end else begin
          dot_cnt = dot_cnt + 9'd1;
        end
      end
      r.busy = dma_on;
      return r;
    endfunction

    function void note_item(bit act, bit [7:0] page);
      lcd_status_t e;
      e = predict_status(act, page);
      items++;
      frames += e.frame;
      dma_reads += e.rd_valid;
      expected_status.push_back(e);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_item(lcd_status_t got);
      lcd_status_t e;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, got %0h", $time, got);
        return;
      end
      e = expected_status.pop_front();
      checked++;
      check_field("lcd_mode", 16'(e.mode), 16'(got.mode));
      check_field("line_number", 16'(e.line), 16'(got.line));
      check_field("dot_number", 16'(e.dot), 16'(got.dot));
      check_field("compare_match", 16'(e.match), 16'(got.match));
      check_field("stat_irq", 16'(e.stat), 16'(got.stat));
      check_field("vblank_irq", 16'(e.vbl), 16'(got.vbl));
      check_field("hblank_pulse", 16'(e.hbl), 16'(got.hbl));
      check_field("frame_done", 16'(e.frame), 16'(got.frame));
      check_field("dma_read_valid", 16'(e.rd_valid), 16'(got.rd_valid));
      check_field("dma_read_address", e.rd_addr, got.rd_addr);
      check_field("oam_byte_index", 16'(e.rd_idx), 16'(got.rd_idx));
      check_field("dma_busy", 16'(e.busy), 16'(got.busy));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   action;
  logic [7:0]             dma_source_page;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             lcd_mode;
  logic [7:0]             line_number;
  logic [8:0]             dot_number;
  logic                   compare_match;
  logic                   stat_irq;
  logic                   vblank_irq;
  logic                   hblank_pulse;
  logic                   frame_done;
  logic                   dma_read_valid;
  logic [15:0]            dma_read_address;
  logic [7:0]             oam_byte_index;
  logic                   dma_busy;
  logic                   cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lcd_status_scoreboard sb;
  bit tx_paced, rx_paced;
  int cycles;

  lcd_line_timing_stat_dma dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dma_source_page(dma_source_page),
    .out_valid(out_valid), .out_ready(out_ready),
    .lcd_mode(lcd_mode), .line_number(line_number), .dot_number(dot_number),
    .compare_match(compare_match), .stat_irq(stat_irq), .vblank_irq(vblank_irq),
    .hblank_pulse(hblank_pulse), .frame_done(frame_done),
    .dma_read_valid(dma_read_valid), .dma_read_address(dma_read_address),
    .oam_byte_index(oam_byte_index), .dma_busy(dma_busy),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_status.size());
      $display("lcd_line_timing_stat_dma_tb: FAIL");
      $finish;
    end
  end

  // unpaced items never wait; paced ones skip the wait a quarter of the time, else draw a gap that may be zero
  function automatic int pick_gap(bit paced);
    if (!paced || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    sb.apply_reg(idx, val);
  endtask

  task automatic load_config(bit disp, bit hbl, bit vbl, bit oam, bit cmp, bit [7:0] line,
                             bit dbl);
    write_reg(CFG_DISPLAY_ENABLE, CFG_DATA_W'(disp));
    write_reg(CFG_HBLANK_IRQ_EN, CFG_DATA_W'(hbl));
    write_reg(CFG_VBLANK_IRQ_EN, CFG_DATA_W'(vbl));
    write_reg(CFG_OAM_IRQ_EN, CFG_DATA_W'(oam));
    write_reg(CFG_COMPARE_IRQ_EN, CFG_DATA_W'(cmp));
    write_reg(CFG_COMPARE_LINE, line);
    write_reg(CFG_DOUBLE_SPEED, CFG_DATA_W'(dbl));
  endtask

  task automatic drive_item(bit act, bit [7:0] page, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    dma_source_page <= page;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_item(act, page);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random ticks with sparse DMA starts, then an unthrottled back-to-back run that also starts DMAs
  task automatic run_phase();
    int i;
    bit act;
    tx_paced = 1'b1;
    rx_paced = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      act = ($urandom_range(0, 39) == 0);
      drive_item(act, 8'($urandom_range(0, 255)), pick_gap(tx_paced));
    end
    tx_paced = 1'b0;
    rx_paced = 1'b0;
    for (i = 0; i < RUN_TICKS + RUN_TAIL; i++) begin
      if (i == RUN_TICKS - 20 && $urandom_range(0, 1) == 0) break;
      // late start keeps a DMA running across the next speed change
      act = (i == RUN_TICKS + RUN_TAIL - LATE_DMA_LEAD) ||
            (i < RUN_TICKS - 40 && $urandom_range(0, 149) == 0);
      drive_item(act, 8'($urandom_range(0, 255)), 0);
    end
    settle();
  endtask

  initial begin
    lcd_status_t got;
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall = pick_gap(rx_paced);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got = lcd_status_t'({lcd_mode, line_number, dot_number, compare_match, stat_irq,
                           vblank_irq, hblank_pulse, frame_done, dma_read_valid,
                           dma_read_address, oam_byte_index, dma_busy});
      sb.check_item(got);
    end
  end

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = 1'b0;
    dma_source_page = '0;
    cfg_write_enable = 1'b0;
    cfg_index = CFG_DISPLAY_ENABLE;
    cfg_data = '0;
    tx_paced = 1'b1;
    rx_paced = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_config(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 1'b0);
    // directed: line 0 match, DMA warm-up and first reads, restarts, back-to-back starts
    drive_item(1'b0, 8'hFF, 0);
    drive_item(1'b1, 8'h00, 0);
    repeat (6) drive_item(1'b0, 8'h00, pick_gap(1'b1));
    drive_item(1'b1, 8'hFF, 0);
    repeat (10) drive_item(1'b0, 8'h5A, 0);
    drive_item(1'b1, 8'hA5, 3);
    drive_item(1'b1, 8'h3C, 0);
    repeat (4) drive_item(1'b0, 8'hC3, pick_gap(1'b1));
    run_phase();

    // display off, double speed, compare against the last line
    load_config(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd153, 1'b1);
    run_phase();

    load_config(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b1, 8'd255, 1'b0);
    run_phase();

    // display on, double speed, compare against line 0
    load_config(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b1);
    run_phase();

    $display("%0d items through four register settings, %0d results checked,", sb.items,
             sb.checked);
    $display("%0d frame ends and %0d DMA byte reads seen", sb.frames, sb.dma_reads);
    if (sb.errors == 0 && sb.expected_status.size() == 0) begin
      $display("lcd_line_timing_stat_dma_tb: PASS");
    end else begin
      $display("lcd_line_timing_stat_dma_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
